/* design/gmf_pkg.sv */
// Shared types and constants for the group membership fan-out table.
// Used by gmf_front, gmf_queue, gmf_back and the top level.
package gmf_pkg;

  localparam int unsigned MemberSlots    = 6;
  localparam int unsigned MaxResults     = 30;
  localparam int unsigned GroupSlotsDef  = 8;
  localparam int unsigned ClientSlotsDef = 8;
  localparam int unsigned QueueDepth     = 2;

  typedef enum logic [2:0] {
    CMD_CREATE   = 3'd0,
    CMD_JOIN     = 3'd1,
    CMD_SEND     = 3'd2,
    CMD_LIST_ALL = 3'd3,
    CMD_LIST_OWN = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    OP_BAD_CLIENT,
    OP_NO_GROUP,
    OP_CREATE,
    OP_JOIN,
    OP_SEND_ONE,
    OP_SEND_ALL,
    OP_LIST_ALL,
    OP_LIST_OWN
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_NO_GRP  = 3'd2,
    ST_MEMBER  = 3'd3,
    ST_FULL    = 3'd4,
    ST_EMPTY   = 3'd5,
    ST_UNKNOWN = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    KIND_STATUS   = 2'd0,
    KIND_DELIVERY = 2'd1,
    KIND_LIST     = 2'd2
  } kind_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] cid;
    logic [15:0] gid;
  } item_t;

  typedef struct packed {
    status_e     status;
    kind_e       kind;
    logic [15:0] member;
    logic [15:0] grp;
  } result_t;

endpackage

/* design/gmf_front.sv */
// Front end: classifies an incoming command into a back-end operation.
// Depends on gmf_pkg.
module gmf_front (
  input  logic           accept_i,
  input  logic [2:0]     cmd_i,
  input  logic [15:0]    client_id_i,
  input  logic [15:0]    group_id_i,
  output logic           push_o,
  output gmf_pkg::item_t item_o
);
  import gmf_pkg::*;

  always_comb begin
    push_o     = accept_i;
    item_o.cid = client_id_i;
    item_o.gid = group_id_i;
    item_o.op  = OP_BAD_CLIENT;
    unique case (cmd_i)
      CMD_CREATE, CMD_JOIN: begin
        if (group_id_i == 16'd0) item_o.op = OP_NO_GROUP;
        else if (cmd_i == CMD_CREATE) item_o.op = OP_CREATE;
        else item_o.op = OP_JOIN;
      end
      CMD_SEND: begin
        item_o.op = (group_id_i == 16'd0) ? OP_SEND_ALL : OP_SEND_ONE;
      end
      CMD_LIST_ALL: item_o.op = OP_LIST_ALL;
      CMD_LIST_OWN: item_o.op = OP_LIST_OWN;
      default: push_o = 1'b0;
    endcase
    if (client_id_i == 16'd0) item_o.op = OP_BAD_CLIENT;
  end

endmodule

/* design/gmf_queue.sv */
// Short queue of classified operations between front and back end.
// Depends on gmf_pkg.
module gmf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gmf_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output gmf_pkg::item_t item_o
);
  import gmf_pkg::*;

  localparam int unsigned PW = $clog2(QueueDepth);

  item_t           mem_q [QueueDepth];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;

  assign full_o  = cnt_q == (PW+1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PW'(QueueDepth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == PW'(QueueDepth - 1)) ? '0 : rp_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

endmodule

/* design/gmf_back.sv */
// Back end: holds the membership tables and executes one operation at a time.
// Depends on gmf_pkg.
module gmf_back #(
  parameter int unsigned GROUP_SLOTS  = gmf_pkg::GroupSlotsDef,
  parameter int unsigned CLIENT_SLOTS = gmf_pkg::ClientSlotsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  gmf_pkg::item_t item_i,
  output logic           pop_o,
  output logic           valid_o,
  output logic [2:0]     status_o,
  output logic [1:0]     kind_o,
  output logic [15:0]    member_id_o,
  output logic [15:0]    group_id_out_o,
  output logic           last_o
);
  import gmf_pkg::*;

  localparam int unsigned GW  = $clog2(GROUP_SLOTS);
  localparam int unsigned CW  = $clog2(CLIENT_SLOTS);
  localparam int unsigned GAW = $clog2(GROUP_SLOTS * MemberSlots);
  localparam int unsigned CAW = $clog2(CLIENT_SLOTS * MemberSlots);
  localparam int unsigned MW  = $clog2(MemberSlots + 1);
  localparam int unsigned NW  = $clog2(MaxResults + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_JRD, S_JCMP, S_JADD, S_FRD, S_FCMP,
    S_SARD, S_SACMP, S_LA, S_LORD, S_LOCMP, S_FIN
  } state_e;

  state_e        state_q;
  op_e           op_q;
  logic [15:0]   cid_q, gid_q, sg_q;
  logic [GW-1:0] g_q, la_q;
  logic [CW-1:0] c_q;
  logic [MW-1:0] idx_q, cnt_q, j_q, ccnt_lat_q;
  status_e       st_q;
  logic [NW-1:0] n_q;
  result_t       pend_q;
  logic          pend_v_q;

  logic [15:0]   gid_tab_q [GROUP_SLOTS];
  logic [MW-1:0] gcnt_q    [GROUP_SLOTS];
  logic [15:0]   cid_tab_q [CLIENT_SLOTS];
  logic [MW-1:0] ccnt_q    [CLIENT_SLOTS];
  logic [15:0]   gmem [GROUP_SLOTS * MemberSlots];
  logic [15:0]   cmem [CLIENT_SLOTS * MemberSlots];
  logic [15:0]   gmem_rd_q, cmem_rd_q;

  logic [15:0]   gkey;
  logic          g_hit, g_free, c_hit, c_free, c_ok, create_ok, join_ok;
  logic [GW-1:0] g_idx, gf_idx;
  logic [CW-1:0] c_idx, cf_idx, c_sel;
  logic [MW-1:0] g_cnt, c_cnt;
  logic          gm_we, cm_we, gm_re, cm_re;
  logic [GAW-1:0] gm_wa, gm_ra;
  logic [CAW-1:0] cm_wa, cm_ra;
  logic          emit_v;
  result_t       emit_r;

  always_comb begin
    gkey   = (state_q == S_SACMP) ? cmem_rd_q : gid_q;
    g_hit  = 1'b0;
    g_idx  = '0;
    g_free = 1'b0;
    gf_idx = '0;
    for (int i = GROUP_SLOTS - 1; i >= 0; i--) begin
      if (gkey != 16'd0 && gid_tab_q[i] == gkey) begin
        g_hit = 1'b1;
        g_idx = GW'(i);
      end
      if (gid_tab_q[i] == 16'd0) begin
        g_free = 1'b1;
        gf_idx = GW'(i);
      end
    end
    c_hit  = 1'b0;
    c_idx  = '0;
    c_free = 1'b0;
    cf_idx = '0;
    for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
      if (cid_tab_q[i] == cid_q) begin
        c_hit = 1'b1;
        c_idx = CW'(i);
      end
      if (cid_tab_q[i] == 16'd0) begin
        c_free = 1'b1;
        cf_idx = CW'(i);
      end
    end
  end

  assign g_cnt = gcnt_q[g_idx];
  assign c_sel = c_hit ? c_idx : cf_idx;
  assign c_cnt = ccnt_q[c_sel];
  assign c_ok  = c_hit ? (c_cnt < MW'(MemberSlots)) : c_free;

  assign create_ok = state_q == S_DECODE && op_q == OP_CREATE && !g_hit && g_free && c_ok;
  assign join_ok   = state_q == S_JADD && c_ok && cnt_q < MW'(MemberSlots);

  assign gm_we = create_ok || join_ok;
  assign gm_wa = create_ok ? GAW'(gf_idx) * GAW'(MemberSlots)
                           : GAW'(g_q) * GAW'(MemberSlots) + GAW'(cnt_q);
  assign gm_re = state_q == S_JRD || state_q == S_FRD;
  assign gm_ra = GAW'(g_q) * GAW'(MemberSlots) + GAW'(idx_q);
  assign cm_we = gm_we;
  assign cm_wa = CAW'(c_sel) * CAW'(MemberSlots) + CAW'(c_cnt);
  assign cm_re = state_q == S_SARD || state_q == S_LORD;
  assign cm_ra = CAW'(c_q) * CAW'(MemberSlots) + CAW'(j_q);

  always_ff @(posedge clk_i) begin
    if (gm_we) gmem[gm_wa] <= cid_q;
    if (gm_re && idx_q < cnt_q) gmem_rd_q <= gmem[gm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cm_we) cmem[cm_wa] <= gid_q;
    if (cm_re && j_q < ccnt_lat_q) cmem_rd_q <= cmem[cm_ra];
  end

  always_comb begin
    emit_v = 1'b0;
    emit_r = '{status: ST_OK, kind: KIND_LIST, member: 16'd0, grp: 16'd0};
    unique case (state_q)
      S_FCMP: begin
        emit_v = gmem_rd_q != cid_q;
        emit_r = '{status: ST_OK, kind: KIND_DELIVERY, member: gmem_rd_q, grp: sg_q};
      end
      S_LA: begin
        emit_v     = gid_tab_q[la_q] != 16'd0;
        emit_r.grp = gid_tab_q[la_q];
      end
      S_LOCMP: begin
        emit_v     = 1'b1;
        emit_r.grp = cmem_rd_q;
      end
      default: emit_v = 1'b0;
    endcase
  end

  assign pop_o = state_q == S_IDLE && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      op_q           <= OP_BAD_CLIENT;
      cid_q          <= '0;
      gid_q          <= '0;
      sg_q           <= '0;
      g_q            <= '0;
      la_q           <= '0;
      c_q            <= '0;
      idx_q          <= '0;
      cnt_q          <= '0;
      j_q            <= '0;
      ccnt_lat_q     <= '0;
      st_q           <= ST_OK;
      n_q            <= '0;
      pend_q         <= '0;
      pend_v_q       <= 1'b0;
      valid_o        <= 1'b0;
      status_o       <= '0;
      kind_o         <= '0;
      member_id_o    <= '0;
      group_id_out_o <= '0;
      last_o         <= 1'b0;
      for (int i = 0; i < GROUP_SLOTS; i++) begin
        gid_tab_q[i] <= '0;
        gcnt_q[i]    <= '0;
      end
      for (int i = 0; i < CLIENT_SLOTS; i++) begin
        cid_tab_q[i] <= '0;
        ccnt_q[i]    <= '0;
      end
    end else begin
      valid_o <= 1'b0;
      last_o  <= 1'b0;

      if (emit_v && n_q < NW'(MaxResults)) begin
        if (pend_v_q) begin
          valid_o        <= 1'b1;
          status_o       <= pend_q.status;
          kind_o         <= pend_q.kind;
          member_id_o    <= pend_q.member;
          group_id_out_o <= pend_q.grp;
        end
        pend_q   <= emit_r;
        pend_v_q <= 1'b1;
        n_q      <= n_q + 1'b1;
      end

      if (gm_we) begin
        if (create_ok) begin
          gid_tab_q[gf_idx] <= gid_q;
          gcnt_q[gf_idx]    <= MW'(1);
        end else begin
          gcnt_q[g_q] <= cnt_q + 1'b1;
        end
        cid_tab_q[c_sel] <= cid_q;
        ccnt_q[c_sel]    <= c_cnt + 1'b1;
      end

      unique case (state_q)
        S_IDLE: begin
          if (valid_i) begin
            op_q    <= item_i.op;
            cid_q   <= item_i.cid;
            gid_q   <= item_i.gid;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          state_q <= S_FIN;
          idx_q   <= '0;
          j_q     <= '0;
          la_q    <= '0;
          st_q    <= ST_EMPTY;
          g_q     <= g_idx;
          cnt_q   <= g_cnt;
          sg_q    <= gid_q;
          c_q     <= c_idx;
          ccnt_lat_q <= c_cnt;
          unique case (op_q)
            OP_BAD_CLIENT: st_q <= ST_UNKNOWN;
            OP_NO_GROUP:   st_q <= ST_NO_GRP;
            OP_CREATE: begin
              if (g_hit) st_q <= ST_EXISTS;
              else if (create_ok) st_q <= ST_OK;
              else st_q <= ST_FULL;
            end
            OP_JOIN: begin
              if (!g_hit) st_q <= ST_NO_GRP;
              else state_q <= S_JRD;
            end
            OP_SEND_ONE: begin
              if (!g_hit) st_q <= ST_NO_GRP;
              else state_q <= S_FRD;
            end
            OP_SEND_ALL: begin
              if (!c_hit) st_q <= ST_UNKNOWN;
              else state_q <= S_SARD;
            end
            OP_LIST_ALL: state_q <= S_LA;
            OP_LIST_OWN: begin
              if (!c_hit) st_q <= ST_UNKNOWN;
              else state_q <= S_LORD;
            end
            default: state_q <= S_FIN;
          endcase
        end
        S_JRD: state_q <= (idx_q >= cnt_q) ? S_JADD : S_JCMP;
        S_JCMP: begin
          if (gmem_rd_q == cid_q) begin
            st_q    <= ST_MEMBER;
            state_q <= S_FIN;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_JRD;
          end
        end
        S_JADD: begin
          st_q    <= join_ok ? ST_OK : ST_FULL;
          state_q <= S_FIN;
        end
        S_FRD: begin
          if (idx_q >= cnt_q) begin
            if (op_q == OP_SEND_ALL) begin
              j_q     <= j_q + 1'b1;
              state_q <= S_SARD;
            end else begin
              state_q <= S_FIN;
            end
          end else begin
            state_q <= S_FCMP;
          end
        end
        S_FCMP: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= S_FRD;
        end
        S_SARD: state_q <= (j_q >= ccnt_lat_q) ? S_FIN : S_SACMP;
        S_SACMP: begin
          if (g_hit) begin
            g_q     <= g_idx;
            cnt_q   <= g_cnt;
            sg_q    <= cmem_rd_q;
            idx_q   <= '0;
            state_q <= S_FRD;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_SARD;
          end
        end
        S_LA: begin
          if (la_q == GW'(GROUP_SLOTS - 1)) state_q <= S_FIN;
          else la_q <= la_q + 1'b1;
        end
        S_LORD: state_q <= (j_q >= ccnt_lat_q) ? S_FIN : S_LOCMP;
        S_LOCMP: begin
          j_q     <= j_q + 1'b1;
          state_q <= S_LORD;
        end
        S_FIN: begin
          valid_o <= 1'b1;
          last_o  <= 1'b1;
          if (pend_v_q) begin
            status_o       <= pend_q.status;
            kind_o         <= pend_q.kind;
            member_id_o    <= pend_q.member;
            group_id_out_o <= pend_q.grp;
          end else begin
            status_o       <= st_q;
            kind_o         <= KIND_STATUS;
            member_id_o    <= '0;
            group_id_out_o <= gid_q;
          end
          pend_v_q <= 1'b0;
          n_q      <= '0;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/group_membership_fanout_table_top.sv */
// Top level of the group membership fan-out table.
// Depends on gmf_pkg, gmf_front, gmf_queue and gmf_back.
//
// Usage: drive cmd_i, client_id_i and group_id_i with start high; the command
// is transferred at a clock edge where start is high and busy is low. busy is
// high only while the two-entry command queue is full.
// Results leave on status_o, kind_o, member_id_o, group_id_out_o and last_o,
// each valid for exactly one cycle while valid_o is high; last_o marks the
// final result of a command. Every command except codes 5 to 7 gives at least
// one result; at most 30 results are given per command.
// Commands are executed one at a time by the back-end sequencer. Join first
// scans the existing members of the group; send reads each member of the
// target group, and a send to all groups first looks up each of the client's
// groups; list all walks every group slot; list own reads each listed group.
// Member lists sit in single-port memories read once per cycle. List all
// results stream at one per cycle; all other results stream more slowly, with
// a memory read state between two results.
// Reset clears all group and client tables and the queue at once.
// The receiver cannot stall; results are never held back.
module group_membership_fanout_table_top #(
  parameter int unsigned GROUP_SLOTS  = gmf_pkg::GroupSlotsDef,
  parameter int unsigned CLIENT_SLOTS = gmf_pkg::ClientSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] client_id_i,
  input  logic [15:0] group_id_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic [1:0]  kind_o,
  output logic [15:0] member_id_o,
  output logic [15:0] group_id_out_o,
  output logic        last_o
);
  import gmf_pkg::*;

  logic  push, q_valid, pop, q_full;
  item_t front_item, q_item;

  assign busy = q_full;

  gmf_front u_front (
    .accept_i    (start && !q_full),
    .cmd_i       (cmd_i),
    .client_id_i (client_id_i),
    .group_id_i  (group_id_i),
    .push_o      (push),
    .item_o      (front_item)
  );

  gmf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (q_item)
  );

  gmf_back #(
    .GROUP_SLOTS  (GROUP_SLOTS),
    .CLIENT_SLOTS (CLIENT_SLOTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (q_item),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .kind_o         (kind_o),
    .member_id_o    (member_id_o),
    .group_id_out_o (group_id_out_o),
    .last_o         (last_o)
  );

endmodule

/* tb/group_membership_fanout_table_top_tb.sv */
// Self-checking testbench for group_membership_fanout_table_top.
// Depends on gmf_pkg; predicts every result from a local copy of the tables
// and checks each result transfer in order, with random gaps on the command side.
`timescale 1ns / 1ps

module group_membership_fanout_table_top_tb;
  import gmf_pkg::*;

  localparam int unsigned NumGroups  = 8;
  localparam int unsigned NumClients = 8;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] cid;
    logic [15:0] gid;
  } command_t;

  typedef struct {
    status_e     status;
    kind_e       kind;
    logic [15:0] member;
    logic [15:0] grp;
    logic        last;
  } delivery_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  cmd_i;
  logic [15:0] client_id_i;
  logic [15:0] group_id_i;
  logic        valid_o;
  logic [2:0]  status_o;
  logic [1:0]  kind_o;
  logic [15:0] member_id_o;
  logic [15:0] group_id_out_o;
  logic        last_o;

  group_membership_fanout_table_top #(
    .GROUP_SLOTS (NumGroups),
    .CLIENT_SLOTS(NumClients)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .client_id_i   (client_id_i),
    .group_id_i    (group_id_i),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .kind_o        (kind_o),
    .member_id_o   (member_id_o),
    .group_id_out_o(group_id_out_o),
    .last_o        (last_o)
  );

  // mirror of the membership tables
  logic [15:0] grp_ids     [NumGroups];
  int          grp_cnt     [NumGroups];
  logic [15:0] grp_members [NumGroups][MemberSlots];
  logic [15:0] cli_ids     [NumClients];
  int          cli_cnt     [NumClients];
  logic [15:0] cli_groups  [NumClients][MemberSlots];

  command_t  pending_cmds[$];
  delivery_t expected_q[$];
  command_t  cur;
  int        gap_left;
  int        issued;
  bit        no_idle;
  int        accepted;
  int        errors;
  int        cycles;
  int        cmd_results;

  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = 1'b1;
      #5 clk_i = 1'b0;
    end
  end

  function automatic int find_grp(logic [15:0] gid);
    if (gid == 0) return -1;
    for (int i = 0; i < NumGroups; i++) if (grp_ids[i] == gid) return i;
    return -1;
  endfunction

  function automatic int find_cli(logic [15:0] cid);
    if (cid == 0) return -1;
    for (int i = 0; i < NumClients; i++) if (cli_ids[i] == cid) return i;
    return -1;
  endfunction

  function automatic int cli_slot_for_add(logic [15:0] cid);
    int c;
    c = find_cli(cid);
    if (c >= 0) return (cli_cnt[c] < MemberSlots) ? c : -1;
    for (int i = 0; i < NumClients; i++) if (cli_ids[i] == 0) return i;
    return -1;
  endfunction

  function automatic void push_result(status_e st, kind_e k, logic [15:0] m,
                                      logic [15:0] g);
    delivery_t r;
    if (cmd_results >= MaxResults) return;
    r.status = st;
    r.kind   = k;
    r.member = m;
    r.grp    = g;
    r.last   = 1'b0;
    expected_q.push_back(r);
    cmd_results++;
  endfunction

  function automatic void fan_out(int g, logic [15:0] sender);
    for (int i = 0; i < grp_cnt[g]; i++)
      if (grp_members[g][i] != sender)
        push_result(ST_OK, KIND_DELIVERY, grp_members[g][i], grp_ids[g]);
  endfunction

  function automatic void add_to_client(int c, logic [15:0] cid, logic [15:0] gid);
    cli_ids[c] = cid;
    cli_groups[c][cli_cnt[c]] = gid;
    cli_cnt[c]++;
  endfunction

  function automatic void predict_command(command_t it);
    int g;
    int c;
    int fg;
    cmd_results = 0;
    if (it.cmd > CMD_LIST_OWN) return;
    if (it.cid == 0) begin
      push_result(ST_UNKNOWN, KIND_STATUS, 16'd0, it.gid);
    end else if (it.cmd == CMD_CREATE) begin
      if (it.gid == 0) begin
        push_result(ST_NO_GRP, KIND_STATUS, 16'd0, it.gid);
      end else if (find_grp(it.gid) >= 0) begin
        push_result(ST_EXISTS, KIND_STATUS, 16'd0, it.gid);
      end else begin
        fg = -1;
        for (int i = NumGroups - 1; i >= 0; i--) if (grp_ids[i] == 0) fg = i;
        c = cli_slot_for_add(it.cid);
        if (fg < 0 || c < 0) begin
          push_result(ST_FULL, KIND_STATUS, 16'd0, it.gid);
        end else begin
          grp_ids[fg] = it.gid;
          grp_members[fg][0] = it.cid;
          grp_cnt[fg] = 1;
          add_to_client(c, it.cid, it.gid);
          push_result(ST_OK, KIND_STATUS, 16'd0, it.gid);
        end
      end
    end else if (it.cmd == CMD_JOIN) begin
      g = find_grp(it.gid);
      if (g < 0) begin
        push_result(ST_NO_GRP, KIND_STATUS, 16'd0, it.gid);
      end else begin
        bit member;
        member = 1'b0;
        for (int i = 0; i < grp_cnt[g]; i++)
          if (grp_members[g][i] == it.cid) member = 1'b1;
        if (member) begin
          push_result(ST_MEMBER, KIND_STATUS, 16'd0, it.gid);
        end else begin
          c = cli_slot_for_add(it.cid);
          if (c < 0 || grp_cnt[g] >= MemberSlots) begin
            push_result(ST_FULL, KIND_STATUS, 16'd0, it.gid);
          end else begin
            grp_members[g][grp_cnt[g]] = it.cid;
            grp_cnt[g]++;
            add_to_client(c, it.cid, it.gid);
            push_result(ST_OK, KIND_STATUS, 16'd0, it.gid);
          end
        end
      end
    end else if (it.cmd == CMD_SEND) begin
      if (it.gid != 0) begin
        g = find_grp(it.gid);
        if (g < 0) begin
          push_result(ST_NO_GRP, KIND_STATUS, 16'd0, it.gid);
        end else begin
          fan_out(g, it.cid);
          if (cmd_results == 0) push_result(ST_EMPTY, KIND_STATUS, 16'd0, it.gid);
        end
      end else begin
        c = find_cli(it.cid);
        if (c < 0) begin
          push_result(ST_UNKNOWN, KIND_STATUS, 16'd0, it.gid);
        end else begin
          for (int i = 0; i < cli_cnt[c]; i++) begin
            g = find_grp(cli_groups[c][i]);
            if (g >= 0) fan_out(g, it.cid);
          end
          if (cmd_results == 0) push_result(ST_EMPTY, KIND_STATUS, 16'd0, it.gid);
        end
      end
    end else if (it.cmd == CMD_LIST_ALL) begin
      for (int i = 0; i < NumGroups; i++)
        if (grp_ids[i] != 0) push_result(ST_OK, KIND_LIST, 16'd0, grp_ids[i]);
      if (cmd_results == 0) push_result(ST_EMPTY, KIND_STATUS, 16'd0, it.gid);
    end else begin
      c = find_cli(it.cid);
      if (c < 0) begin
        push_result(ST_UNKNOWN, KIND_STATUS, 16'd0, it.gid);
      end else begin
        for (int i = 0; i < cli_cnt[c]; i++)
          push_result(ST_OK, KIND_LIST, 16'd0, cli_groups[c][i]);
        if (cmd_results == 0) push_result(ST_EMPTY, KIND_STATUS, 16'd0, it.gid);
      end
    end
    if (cmd_results > 0) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  // command driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_command(cur);
        accepted++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur = pending_cmds.pop_front();
          cmd_i       <= cur.cmd;
          client_id_i <= cur.cid;
          group_id_i  <= cur.gid;
          start       <= 1'b1;
          issued++;
          if (issued % 20 == 0) no_idle = ~no_idle;
          gap_left = no_idle ? 0 : $urandom_range(0, 16);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    delivery_t e;
    cycles++;
    if (rst_ni && valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d kind=%0d member=%h grp=%h last=%b",
                 $time, status_o, kind_o, member_id_o, group_id_out_o, last_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          errors++;
        end
        if (kind_o !== e.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind_o);
          errors++;
        end
        if (member_id_o !== e.member) begin
          $display("%0t: member expected %h actual %h", $time, e.member, member_id_o);
          errors++;
        end
        if (group_id_out_o !== e.grp) begin
          $display("%0t: group expected %h actual %h", $time, e.grp, group_id_out_o);
          errors++;
        end
        if (last_o !== e.last) begin
          $display("%0t: last expected %b actual %b", $time, e.last, last_o);
          errors++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_cmd(logic [2:0] c, logic [15:0] cid, logic [15:0] gid);
    command_t it;
    it.cmd = c;
    it.cid = cid;
    it.gid = gid;
    pending_cmds.push_back(it);
  endtask

  initial begin
    logic [15:0] cid_pool[12];
    logic [15:0] gid_pool[12];
    int          total;
    int          r;
    logic [2:0]  c;
    logic [15:0] cid;
    logic [15:0] gid;

    for (int i = 0; i < NumGroups; i++) begin
      grp_ids[i] = 0;
      grp_cnt[i] = 0;
    end
    for (int i = 0; i < NumClients; i++) begin
      cli_ids[i] = 0;
      cli_cnt[i] = 0;
    end
    start = 1'b0;
    cmd_i = '0;
    client_id_i = '0;
    group_id_i = '0;
    gap_left = 0;
    issued = 0;
    no_idle = 1'b0;
    accepted = 0;
    errors = 0;
    cycles = 0;
    rst_ni = 1'b0;

    // directed part
    add_cmd(CMD_CREATE, 16'd0, 16'd5);
    add_cmd(CMD_CREATE, 16'd1, 16'd0);
    add_cmd(CMD_LIST_ALL, 16'd1, 16'hFFFF);
    add_cmd(CMD_LIST_OWN, 16'd1, 16'd3);
    add_cmd(CMD_SEND, 16'd1, 16'd0);
    add_cmd(CMD_SEND, 16'd1, 16'd7);
    add_cmd(CMD_JOIN, 16'd1, 16'd7);
    add_cmd(CMD_CREATE, 16'd1, 16'hFFFF);
    add_cmd(CMD_SEND, 16'd1, 16'hFFFF);
    add_cmd(CMD_CREATE, 16'hFFFF, 16'hFFFF);
    add_cmd(CMD_JOIN, 16'd1, 16'hFFFF);
    for (int i = 2; i <= 7; i++) add_cmd(CMD_JOIN, 16'(i * 4369), 16'hFFFF);
    add_cmd(CMD_SEND, 16'hFFFF, 16'hFFFF);
    add_cmd(CMD_SEND, 16'd1, 16'd0);
    add_cmd(CMD_LIST_ALL, 16'h8000, 16'd0);
    add_cmd(CMD_LIST_OWN, 16'h4444, 16'd0);
    add_cmd(3'd5, 16'd1, 16'd1);
    add_cmd(3'd6, 16'h5555, 16'hAAAA);
    add_cmd(3'd7, 16'hAAAA, 16'h5555);
    add_cmd(CMD_JOIN, 16'd0, 16'hFFFF);

    // random part: small id pools so tables fill and fan-outs grow
    cid_pool[0] = 16'd1;
    cid_pool[1] = 16'hFFFF;
    gid_pool[0] = 16'hFFFF;
    gid_pool[1] = 16'd1;
    for (int i = 2; i < 12; i++) begin
      cid_pool[i] = 16'($urandom_range(1, 65535));
      gid_pool[i] = 16'($urandom_range(1, 65535));
    end
    total = 0;
    while (total < 82) begin
      r = $urandom_range(0, 99);
      if (r < 25) c = CMD_CREATE;
      else if (r < 55) c = CMD_JOIN;
      else if (r < 80) c = CMD_SEND;
      else if (r < 87) c = CMD_LIST_ALL;
      else if (r < 95) c = CMD_LIST_OWN;
      else c = 3'($urandom_range(5, 7));
      cid = cid_pool[$urandom_range(0, 11)];
      gid = gid_pool[$urandom_range(0, 11)];
      if ($urandom_range(0, 29) == 0) cid = 16'd0;
      if ($urandom_range(0, 9) == 0) gid = ($urandom_range(0, 1) == 0) ? 16'd0 :
                                           16'($urandom_range(0, 65535));
      if (c == CMD_SEND && $urandom_range(0, 3) == 0) gid = 16'd0;
      add_cmd(c, cid, gid);
      if (c <= CMD_LIST_OWN) total++;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_cmds.size() == 0 && accepted == issued && !start);
    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk_i);

    if (errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (expected_q.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
